@@ rtl/itr_pkg.sv @@
// Package for the integer to Roman numeral emitter: states, limits and token tables.
package itr_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ERR
    } t_state;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned SYMBOL_W = 7;
    localparam int unsigned TOK_N    = 13;
    localparam int unsigned TOK_W    = $clog2(TOK_N);

    localparam logic [VALUE_W-1:0]  MAX_VALID = 12'd3999;
    localparam logic [SYMBOL_W-1:0] SYM_NONE  = 7'd0;
    localparam logic [SYMBOL_W-1:0] SYM_I     = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V     = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X     = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L     = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C     = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D     = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M     = 7'h4D;

    // Greedy token list, largest first: M CM D CD C XC L XL X IX V IV I
    function automatic logic [VALUE_W-1:0] tok_value(input logic [TOK_W-1:0] idx);
        case (idx)
            4'd0:    tok_value = 12'd1000;
            4'd1:    tok_value = 12'd900;
            4'd2:    tok_value = 12'd500;
            4'd3:    tok_value = 12'd400;
            4'd4:    tok_value = 12'd100;
            4'd5:    tok_value = 12'd90;
            4'd6:    tok_value = 12'd50;
            4'd7:    tok_value = 12'd40;
            4'd8:    tok_value = 12'd10;
            4'd9:    tok_value = 12'd9;
            4'd10:   tok_value = 12'd5;
            4'd11:   tok_value = 12'd4;
            4'd12:   tok_value = 12'd1;
            default: tok_value = 12'd1;
        endcase
    endfunction

    // First character of a token
    function automatic logic [SYMBOL_W-1:0] tok_first(input logic [TOK_W-1:0] idx);
        case (idx)
            4'd0:    tok_first = SYM_M;
            4'd1:    tok_first = SYM_C;
            4'd2:    tok_first = SYM_D;
            4'd3:    tok_first = SYM_C;
            4'd4:    tok_first = SYM_C;
            4'd5:    tok_first = SYM_X;
            4'd6:    tok_first = SYM_L;
            4'd7:    tok_first = SYM_X;
            4'd8:    tok_first = SYM_X;
            4'd9:    tok_first = SYM_I;
            4'd10:   tok_first = SYM_V;
            4'd11:   tok_first = SYM_I;
            4'd12:   tok_first = SYM_I;
            default: tok_first = SYM_I;
        endcase
    endfunction

    // Second character of a subtractive pair
    function automatic logic [SYMBOL_W-1:0] tok_second(input logic [TOK_W-1:0] idx);
        case (idx)
            4'd1:    tok_second = SYM_M;
            4'd3:    tok_second = SYM_D;
            4'd5:    tok_second = SYM_C;
            4'd7:    tok_second = SYM_L;
            4'd9:    tok_second = SYM_X;
            4'd11:   tok_second = SYM_V;
            default: tok_second = SYM_NONE;
        endcase
    endfunction

    // Subtractive pairs sit at the odd places of the list
    function automatic logic tok_pair(input logic [TOK_W-1:0] idx);
        tok_pair = idx[0] && (idx < 4'd12);
    endfunction

endpackage

@@ rtl/integer_to_roman_emitter.sv @@
// Integer to Roman numeral emitter: greedy token sequencer over one shared subtractor.
// The first character is registered after the item is accepted, once every token too
//   large for the value has been skipped. One item is in work at a time: a new one is
//   taken only in idle. An out-of-range value yields a single error item.
// One subtract/compare unit against the token table sets the pace: one step per cycle
//   while the receiver does not stall.
// Synchronous active-low reset returns the sequencer to idle with no result pending.
module integer_to_roman_emitter
    import itr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SYMBOL_W-1:0] o_symbol,
    output logic                o_last,
    output logic                o_error
);

    t_state              r_state, n_state;
    logic [VALUE_W-1:0]  r_rem, n_rem;
    logic [TOK_W-1:0]    r_idx, n_idx;
    logic                r_half, n_half;
    logic                r_out_valid, n_out_valid;
    logic [SYMBOL_W-1:0] r_symbol, n_symbol;
    logic                r_last, n_last;
    logic                r_error, n_error;

    logic                w_accept;
    logic                w_bad;
    logic                w_free;
    logic [VALUE_W-1:0]  w_tok_val;
    logic [VALUE_W:0]    w_diff;
    logic                w_ge;
    logic                w_zero;
    logic                w_emit;
    logic                w_char_last;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_bad    = (i_value == '0) || (i_value > MAX_VALID);
    assign w_free   = !r_out_valid || !i_stall;

    // Shared subtract/compare unit against the current token
    assign w_tok_val   = tok_value(r_idx);
    assign w_diff      = {1'b0, r_rem} - {1'b0, w_tok_val};
    assign w_ge        = !w_diff[VALUE_W];
    assign w_zero      = (w_diff[VALUE_W-1:0] == '0);
    assign w_emit      = (r_state == ST_RUN) && w_free && (r_half || w_ge);
    assign w_char_last = (r_half || !tok_pair(r_idx)) && w_zero;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_bad ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_emit && w_char_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (w_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and output register next values
    always_comb begin
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_half      = r_half;
        n_out_valid = r_out_valid;
        n_symbol    = r_symbol;
        n_last      = r_last;
        n_error     = r_error;
        if (w_free) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_rem  = i_value;
                    n_idx  = '0;
                    n_half = 1'b0;
                end
            end
            ST_RUN: begin
                if (w_free) begin
                    if (r_half) begin
                        // second character of a subtractive pair
                        n_out_valid = 1'b1;
                        n_symbol    = tok_second(r_idx);
                        n_last      = w_char_last;
                        n_error     = 1'b0;
                        n_rem       = w_diff[VALUE_W-1:0];
                        n_half      = 1'b0;
                    end else if (w_ge) begin
                        n_out_valid = 1'b1;
                        n_symbol    = tok_first(r_idx);
                        n_last      = w_char_last;
                        n_error     = 1'b0;
                        if (tok_pair(r_idx)) begin
                            n_half = 1'b1;
                        end else begin
                            n_rem = w_diff[VALUE_W-1:0];
                        end
                    end else begin
                        // token too large: move to the next one
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_ERR: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_symbol    = SYM_NONE;
                    n_last      = 1'b1;
                    n_error     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_half      <= n_half;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_idx    <= n_idx;
        r_symbol <= n_symbol;
        r_last   <= n_last;
        r_error  <= n_error;
    end

    assign o_valid  = r_out_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;
    assign o_error  = r_error;

    // An error item is always a single zero-symbol final item
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_last && (o_symbol == SYM_NONE)))
        else $error("error item without last or with nonzero symbol");

    // An out-of-range value goes straight to the error state
    a_bad_to_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_bad) |=> (r_state == ST_ERR))
        else $error("out-of-range value did not enter error state");

    // A pending pair second character always has remainder to cover it
    a_half_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_half) |-> w_ge)
        else $error("pair pending without enough remainder");

    // Remainder never runs out while the sequencer still works
    a_rem_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_rem != '0))
        else $error("running with zero remainder");

endmodule

@@ tb/sv/tb.sv @@
// Integer to Roman emitter testbench: directed, random, backpressure and drain-pause tests.
module tb
    import itr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 400;

    // One expected character of a numeral
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                error;
    } t_roman_char;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [SYMBOL_W-1:0] o_symbol;
    logic                o_last;
    logic                o_error;

    t_roman_char expected_chars[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    integer_to_roman_emitter i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_symbol (o_symbol),
        .o_last   (o_last),
        .o_error  (o_error)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Queue one character of the numeral
    function automatic void push_symbol(logic [SYMBOL_W-1:0] sym);
        t_roman_char c;
        c.symbol = sym;
        c.last   = 1'b0;
        c.error  = 1'b0;
        expected_chars.insert(expected_chars.size(), c);
    endfunction

    // One decimal digit from its place's one, five and ten symbols
    function automatic void push_digit(int digit, logic [SYMBOL_W-1:0] one,
                                       logic [SYMBOL_W-1:0] five,
                                       logic [SYMBOL_W-1:0] ten);
        int d;
        d = digit;
        if (d == 9) begin
            push_symbol(one);
            push_symbol(ten);
        end else if (d == 4) begin
            push_symbol(one);
            push_symbol(five);
        end else begin
            if (d >= 5) begin
                push_symbol(five);
                d -= 5;
            end
            for (int k = 0; k < d; k++) push_symbol(one);
        end
    endfunction

    // Expected characters for one accepted value
    function automatic void push_roman_numeral(logic [VALUE_W-1:0] v);
        t_roman_char c;
        int n;
        n = int'(v);
        if (v == '0 || v > MAX_VALID) begin
            c.symbol = SYM_NONE;
            c.last   = 1'b1;
            c.error  = 1'b1;
            expected_chars.insert(expected_chars.size(), c);
        end else begin
            for (int k = 0; k < n / 1000; k++) push_symbol(SYM_M);
            push_digit((n / 100) % 10, SYM_C, SYM_D, SYM_M);
            push_digit((n / 10) % 10, SYM_X, SYM_L, SYM_C);
            push_digit(n % 10, SYM_I, SYM_V, SYM_X);
            expected_chars[expected_chars.size() - 1].last = 1'b1;
        end
    endfunction

    // Monitor: predict on input items, check output items, watch for a hang
    always @(posedge i_clk) begin
        t_roman_char exp_c;
        if (i_rst_n) begin
            if (i_valid && !o_stall) push_roman_numeral(i_value);
            if (o_valid && !i_stall) begin
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected item symbol=%h last=%b error=%b",
                             $time, o_symbol, o_last, o_error);
                end else begin
                    exp_c = expected_chars.pop_front();
                    if (o_symbol !== exp_c.symbol) begin
                        mismatches++;
                        $display("%0t: symbol expected %h actual %h",
                                 $time, exp_c.symbol, o_symbol);
                    end
                    if (o_last !== exp_c.last) begin
                        mismatches++;
                        $display("%0t: last expected %b actual %b",
                                 $time, exp_c.last, o_last);
                    end
                    if (o_error !== exp_c.error) begin
                        mismatches++;
                        $display("%0t: error expected %b actual %b",
                                 $time, exp_c.error, o_error);
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: long hold on request, otherwise a changing stall pattern
    initial begin
        int rx_mode;
        int mode_left;
        int phase;
        rx_mode   = 0;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_stall  <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(64, 256);
                end
                mode_left--;
                phase++;
                case (rx_mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 9) < 6);
                    default: i_stall <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    // Offer one item and wait until it is taken
    task automatic send_value(input logic [VALUE_W-1:0] v);
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Sender pacing: bursts of random length with random gaps between them
    task automatic sender_gap();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering and wait until every expected character has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_chars.size() != 0);
    endtask

    // Mostly valid values, many small, some out of range
    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) return (pick == 0) ? '0 : VALUE_W'($urandom_range(4000, 4095));
        if (pick < 7) return VALUE_W'($urandom_range(1, 99));
        if (pick < 9) return VALUE_W'($urandom_range(3000, 3999));
        return VALUE_W'($urandom_range(1, 3999));
    endfunction

    // Field extremes, fours, fives and nines in each place, the longest numeral and errors
    task automatic test_directed();
        logic [VALUE_W-1:0] vals[24] = '{
            12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
            12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000,
            12'd3000, 12'd1994, 12'd444, 12'd999, 12'd3, 12'd8, 12'd2048, 12'd2730
        };
        foreach (vals[k]) begin
            send_value(vals[k]);
            sender_gap();
        end
        wait_drained();
    endtask

    // Random values under random sender gaps and receiver stalls
    task automatic test_random_values();
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            send_value(random_value());
            sender_gap();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 24; k++) send_value(random_value());
        i_valid <= 1'b0;
        do @(posedge i_clk); while (hold_req || hold_left != 0);
    endtask

    // Sender pauses until the block has emitted everything, then resumes
    task automatic test_drain_pause();
        for (int k = 0; k < 12; k++) begin
            send_value(random_value());
            if (k % 4 == 3) wait_drained();
        end
    endtask

    // Test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_values();
        test_backpressure();
        test_drain_pause();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/itr_pkg.sv
rtl/integer_to_roman_emitter.sv
tb/sv/tb.sv
